@@ rtl/tppd_pkg.sv @@
// Shared widths, register codes and structs of the thermal pass peak detector.
package tppd_pkg;

  // Field widths
  localparam int RAW_W      = 16;
  localparam int IDX_W      = 3;
  localparam int TEMP_W     = 18;
  localparam int SUM_W      = 21;
  localparam int AVG_W      = 18;
  localparam int PEAK_W     = 17;
  localparam int CNT_W      = 10;
  localparam int RISE_W     = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;
  // Wide enough for sensors * ambient * (100 + rise) and round sum * 100
  localparam int THR_W      = 34;

  // Raw sensor word of 0 degC, in 0.02 K steps
  localparam logic [RAW_W-1:0] RAW_OFFSET = 16'd13658;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AMBIENT      = 2'd0,
    CFG_RISE         = 2'd1,
    CFG_MIN_LOGGED   = 2'd2,
    CFG_WINDOW_LIMIT = 2'd3
  } cfg_reg_e;

  // Register values as the datapath sees them
  typedef struct packed {
    logic signed [TEMP_W-1:0] ambient;
    logic [CNT_W-1:0]         min_logged;
    logic [CNT_W-1:0]         window_limit;
    logic signed [THR_W-1:0]  threshold;
  } cfg_t;

  // One captured reading
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     ok;
    logic signed [TEMP_W-1:0] temp;
  } item_t;

  // Per-reading result of the round and window logic
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     done;
    logic signed [SUM_W-1:0]  sum;
    logic                     logged;
    logic                     peak_valid;
    logic [PEAK_W-1:0]        peak;
    logic                     alarm;
  } core_res_t;

endpackage

@@ rtl/tppd_cfg.sv @@
// Configuration registers and the registered logging threshold.
module tppd_cfg #(
  parameter int SENSORS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [tppd_pkg::CFG_ADDR_W-1:0]   addr_i,
  input  logic [tppd_pkg::CFG_DATA_W-1:0]   wdata_i,
  output tppd_pkg::cfg_t                    cfg_o
);
  import tppd_pkg::*;

  localparam int FS_W = RISE_W + 2 + $clog2(SENSORS + 1);
  localparam logic signed [THR_W-1:0] THR_RST = THR_W'(2500 * 101 * SENSORS);

  logic signed [TEMP_W-1:0] ambient_q;
  logic [RISE_W-1:0]        rise_q;
  logic [CNT_W-1:0]         min_logged_q;
  logic [CNT_W-1:0]         window_limit_q;
  logic signed [THR_W-1:0]  thr_q;
  logic signed [THR_W-1:0]  thr_d;
  logic [FS_W-1:0]          scale;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q      <= TEMP_W'(2500);
      rise_q         <= RISE_W'(1);
      min_logged_q   <= CNT_W'(40);
      window_limit_q <= CNT_W'(300);
    end else if (we_i) begin
      case (cfg_reg_e'(addr_i))
        CFG_AMBIENT:      ambient_q      <= wdata_i[TEMP_W-1:0];
        CFG_RISE:         rise_q         <= wdata_i[RISE_W-1:0];
        CFG_MIN_LOGGED:   min_logged_q   <= wdata_i[CNT_W-1:0];
        CFG_WINDOW_LIMIT: window_limit_q <= wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Threshold: sensors * ambient * (100 + rise), compared against sum * 100
  always_comb begin
    scale = (FS_W'(rise_q) + FS_W'(100)) * FS_W'(SENSORS);
    thr_d = THR_W'(ambient_q) * THR_W'($signed({1'b0, scale}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign cfg_o.ambient      = ambient_q;
  assign cfg_o.min_logged   = min_logged_q;
  assign cfg_o.window_limit = window_limit_q;
  assign cfg_o.threshold    = thr_q;

endmodule

@@ rtl/tppd_core.sv @@
// Round sum, last good values per sensor and the logging window with its peak.
module tppd_core #(
  parameter int SENSORS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  tppd_pkg::item_t       item_i,
  input  tppd_pkg::cfg_t        cfg_i,
  output tppd_pkg::core_res_t   res_o
);
  import tppd_pkg::*;

  localparam int SEL_W = IDX_W + $clog2(SENSORS + 1);
  localparam logic [SEL_W-1:0] LAST_IDX = SEL_W'(SENSORS - 1);
  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};
  localparam logic signed [THR_W-1:0] PCT = THR_W'(100);

  logic signed [TEMP_W-1:0] last_good_q [SENSORS];
  logic signed [TEMP_W-1:0] last_good_d [SENSORS];
  logic signed [SUM_W-1:0]  round_sum_q;
  logic [CNT_W-1:0]         logged_q;
  logic [PEAK_W-1:0]        run_peak_q;

  logic [SEL_W-1:0]         idx;
  logic                     wr;
  logic                     closing;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_new;
  logic signed [THR_W-1:0]  lhs;
  logic                     room;
  logic                     log_it;
  logic                     close_win;
  logic                     pv;
  logic [PEAK_W-1:0]        peak_new;

  always_comb begin
    idx     = SEL_W'(item_i.idx);
    wr      = item_i.ok && (idx < SEL_W'(SENSORS));
    closing = (idx == LAST_IDX);

    // Add a good reading, saturate to the sum range
    sum_wide = (SUM_W+1)'(round_sum_q) + (SUM_W+1)'(item_i.temp);
    if (!wr) begin
      sum_new = round_sum_q;
    end else if (sum_wide > SUM_MAX) begin
      sum_new = SUM_MAX[SUM_W-1:0];
    end else if (sum_wide < SUM_MIN) begin
      sum_new = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_new = sum_wide[SUM_W-1:0];
    end

    // Last good values with this reading applied
    for (int i = 0; i < SENSORS; i++) begin
      last_good_d[i] = (wr && idx == SEL_W'(i)) ? item_i.temp : last_good_q[i];
    end

    // Peak over the window so far and the last good values, negatives count as zero
    peak_new = run_peak_q;
    for (int i = 0; i < SENSORS; i++) begin
      if (!last_good_d[i][TEMP_W-1] && (PEAK_W'(last_good_d[i]) > peak_new)) begin
        peak_new = PEAK_W'(last_good_d[i]);
      end
    end

    // Round average against ambient raised by rise percent, without a divide
    lhs       = THR_W'(sum_new) * PCT;
    room      = ((CNT_W+1)'(logged_q) + (CNT_W+1)'(SENSORS)) < (CNT_W+1)'(cfg_i.window_limit);
    log_it    = closing && (lhs >= cfg_i.threshold) && room;
    close_win = closing && !log_it;
    pv        = close_win && (logged_q >= cfg_i.min_logged);

    res_o.temp       = item_i.ok ? item_i.temp : '0;
    res_o.done       = closing;
    res_o.sum        = sum_new;
    res_o.logged     = log_it;
    res_o.peak_valid = pv;
    res_o.peak       = pv ? run_peak_q : '0;
    res_o.alarm      = pv && ($signed({2'b00, run_peak_q}) >=
                              $signed({cfg_i.ambient[TEMP_W-1], cfg_i.ambient}));
  end

  // Advance the round and window state once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSORS; i++) begin
        last_good_q[i] <= '0;
      end
      round_sum_q <= '0;
      logged_q    <= '0;
      run_peak_q  <= '0;
    end else if (adv_i) begin
      for (int i = 0; i < SENSORS; i++) begin
        last_good_q[i] <= last_good_d[i];
      end
      round_sum_q <= closing ? '0 : sum_new;
      if (log_it) begin
        run_peak_q <= peak_new;
        logged_q   <= logged_q + CNT_W'(SENSORS);
      end else if (close_win) begin
        run_peak_q <= '0;
        logged_q   <= '0;
      end
    end
  end

endmodule

@@ rtl/tppd_avg.sv @@
// Round average: signed sum divided by the sensor count via a reciprocal multiply.
module tppd_avg #(
  parameter int SENSORS = 6
) (
  input  logic                                  done_i,
  input  logic signed [tppd_pkg::SUM_W-1:0]     sum_i,
  output logic signed [tppd_pkg::AVG_W-1:0]     avg_o
);
  import tppd_pkg::*;

  localparam int DIV_SH = SUM_W + $clog2(SENSORS) + 1;
  localparam int MUL_W  = DIV_SH + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << DIV_SH) + 64'(SENSORS) - 64'd1) / 64'(SENSORS));
  localparam logic [SUM_W-1:0] Q_POS_MAX = SUM_W'((2 ** (AVG_W - 1)) - 1);
  localparam logic [SUM_W-1:0] Q_NEG_MAX = SUM_W'(2 ** (AVG_W - 1));

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]  quot_n;

  // Divide the magnitude, truncate toward zero, restore sign and saturate; zero unless done_i
  always_comb begin
    neg    = sum_i[SUM_W-1];
    mag    = neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    prod   = PROD_W'(mag) * PROD_W'(RECIP);
    quot   = SUM_W'(prod >> DIV_SH);
    quot_n = SUM_W'(0) - quot;
    if (!done_i) begin
      avg_o = '0;
    end else if (!neg) begin
      avg_o = (quot > Q_POS_MAX) ? AVG_W'(Q_POS_MAX) : AVG_W'(quot);
    end else begin
      avg_o = (quot > Q_NEG_MAX) ? {1'b1, {(AVG_W-1){1'b0}}} : AVG_W'(quot_n);
    end
  end

endmodule

@@ rtl/thermal_pass_peak_detector.sv @@
// Top level of the thermal pass peak detector: stream stages and configuration.
//
// Usage: one sensor reading per slave transaction; raw word in s_axis_tdata,
// sensor index and read status in s_axis_tuser. Sensor SENSORS-1 closes a round.
// Every reading yields one master transaction with the converted temperature,
// zero for a failed read; a closing reading also carries the round average,
// whether the round was logged, and, when the window closed full enough, its peak and alarm flag.
// m_axis_tlast marks the closing reading of a round.
// Configuration registers are written through cfg_we_i / cfg_addr_i /
// cfg_wdata_i; the user must write them only while no transaction is in
// flight, which the block does not enforce. The threshold they feed is
// registered again from the written values in thr_q. An accepted reading
// passes the input, round/window and average registers to the master side.
// Throughput: one reading per cycle while the master side does not stall, set by the round update.
// A stalled master side fills the three stages, then drops s_axis_tready;
// empty stages keep taking readings while a result waits.
// Reset clears every stage valid, the per-sensor values, the round sum and the window,
// and loads the registers with their default values.
module thermal_pass_peak_detector #(
  parameter int SENSORS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // raw_word[15:0]
  input  logic [3:0]                          s_axis_tuser,  // sensor_index[2:0], read_ok[3]
  // Master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // temp_centi[17:0], average_centi[35:18], peak_centi[52:36], alarm[53], zero[55:54]
  output logic [55:0]                         m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // window_logged[0], peak_valid[1]
  output logic                                m_axis_tlast,  // round_done
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [tppd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [tppd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import tppd_pkg::*;

  cfg_t                     cfg;
  item_t                    item_d;
  item_t                    item_q;
  core_res_t                res_d;
  core_res_t                res_q;
  logic                     v1_q;
  logic                     v2_q;
  logic                     v3_q;
  logic                     en1;
  logic                     en2;
  logic                     en3;
  logic signed [TEMP_W-1:0] diff;
  logic signed [AVG_W-1:0]  avg_d;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic signed [AVG_W-1:0]  out_avg_q;
  logic [PEAK_W-1:0]        out_peak_q;
  logic                     out_alarm_q;
  logic                     out_logged_q;
  logic                     out_pv_q;
  logic                     out_done_q;

  // Stage enables: a stage loads when it is empty or its content moves on
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  // Convert the raw word to hundredths of a degree
  always_comb begin
    diff        = TEMP_W'({1'b0, s_axis_tdata}) - TEMP_W'({1'b0, RAW_OFFSET});
    item_d.idx  = s_axis_tuser[IDX_W-1:0];
    item_d.ok   = s_axis_tuser[IDX_W];
    item_d.temp = diff <<< 1;
  end

  tppd_cfg #(
    .SENSORS(SENSORS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .addr_i (cfg_addr_i),
    .wdata_i(cfg_wdata_i),
    .cfg_o  (cfg)
  );

  tppd_core #(
    .SENSORS(SENSORS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (v1_q && en2),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  tppd_avg #(
    .SENSORS(SENSORS)
  ) u_avg (
    .done_i(res_q.done),
    .sum_i (res_q.sum),
    .avg_o (avg_d)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= s_axis_tvalid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      item_q <= item_d;
    end
    if (en2) begin
      res_q <= res_d;
    end
    if (en3) begin
      out_temp_q   <= res_q.temp;
      out_avg_q    <= avg_d;
      out_peak_q   <= res_q.peak;
      out_alarm_q  <= res_q.alarm;
      out_logged_q <= res_q.logged;
      out_pv_q     <= res_q.peak_valid;
      out_done_q   <= res_q.done;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {2'b00, out_alarm_q, out_peak_q, out_avg_q, out_temp_q};
  assign m_axis_tuser  = {out_pv_q, out_logged_q};
  assign m_axis_tlast  = out_done_q;

endmodule
